@@ rtl/fskd_pkg.sv @@
// Shared types and constants of the FSK tape bit demodulator.
// Used by every module under rtl but fskd_checker; depends on nothing.
package fskd_pkg;

	localparam int FILL_MAX = 63;
	localparam int GAP_W    = 16;
	localparam int FILL_W   = $clog2(FILL_MAX + 1);
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;
	localparam int QUEUE_DEPTH = 2;

	// Register indexes (byte address is 4 * index)
	typedef enum logic [2:0] {
		REG_MID_LEVEL  = 3'd0,
		REG_SHORT_MIN  = 3'd1,
		REG_SHORT_MAX  = 3'd2,
		REG_LONG_MIN   = 3'd3,
		REG_LONG_MAX   = 3'd4,
		REG_GAP_LIMIT  = 3'd5,
		REG_BIT_PERIOD = 3'd6,
		REG_UNUSED     = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [7:0]  mid_level;
		logic [7:0]  short_min;
		logic [7:0]  short_max;
		logic [7:0]  long_min;
		logic [7:0]  long_max;
		logic [15:0] gap_limit;
		logic [15:0] bit_period;
	} cfg_t;

	// One decoded bit handed from the front to the back
	typedef struct packed {
		logic             bit_val;
		logic             first;
		logic [GAP_W-1:0] gap;
	} evt_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_COUNT,
		BK_EMIT
	} bk_state_t;

endpackage

@@ rtl/fskd_regs.sv @@
// Configuration register file behind the APB-style port.
// Depends on fskd_pkg.
module fskd_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [fskd_pkg::ADDR_W-1:0] paddr,
	input  logic [fskd_pkg::DATA_W-1:0] pwdata,
	output logic [fskd_pkg::DATA_W-1:0] prdata,
	output fskd_pkg::cfg_t             cfg
);
	import fskd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx   = reg_idx_t'(paddr[4:2]);
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mid_level  <= 8'd128;
			cfg_q.short_min  <= 8'd9;
			cfg_q.short_max  <= 8'd16;
			cfg_q.long_min   <= 8'd17;
			cfg_q.long_max   <= 8'd22;
			cfg_q.gap_limit  <= 16'd441;
			cfg_q.bit_period <= 16'd329;
		end else if (wr_en) begin
			unique case (idx)
				REG_MID_LEVEL:  cfg_q.mid_level  <= pwdata[7:0];
				REG_SHORT_MIN:  cfg_q.short_min  <= pwdata[7:0];
				REG_SHORT_MAX:  cfg_q.short_max  <= pwdata[7:0];
				REG_LONG_MIN:   cfg_q.long_min   <= pwdata[7:0];
				REG_LONG_MAX:   cfg_q.long_max   <= pwdata[7:0];
				REG_GAP_LIMIT:  cfg_q.gap_limit  <= pwdata[15:0];
				REG_BIT_PERIOD: cfg_q.bit_period <= pwdata[15:0];
				REG_UNUSED:     ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MID_LEVEL:  prdata = {24'd0, cfg_q.mid_level};
			REG_SHORT_MIN:  prdata = {24'd0, cfg_q.short_min};
			REG_SHORT_MAX:  prdata = {24'd0, cfg_q.short_max};
			REG_LONG_MIN:   prdata = {24'd0, cfg_q.long_min};
			REG_LONG_MAX:   prdata = {24'd0, cfg_q.long_max};
			REG_GAP_LIMIT:  prdata = {16'd0, cfg_q.gap_limit};
			REG_BIT_PERIOD: prdata = {16'd0, cfg_q.bit_period};
			REG_UNUSED:     prdata = '0;
		endcase
	end

endmodule

@@ rtl/fskd_front.sv @@
// Front end: level compare, pulse classification, pattern match.
// Depends on fskd_pkg; pushes decoded bits into fskd_queue.
module fskd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  fskd_pkg::cfg_t cfg,
	input  logic           take,
	input  logic [7:0]     sample,
	output logic           push,
	output fskd_pkg::evt_t push_evt
);
	import fskd_pkg::*;

	logic             level_low_q;
	logic [7:0]       interval_q;
	logic             prev_long_q;
	logic [7:0]       short_q;
	logic [7:0]       long_q;
	logic [GAP_W-1:0] since_q;
	logic             no_bit_yet_q;

	logic             low, rise, is_short, is_long, pulse;
	logic [7:0]       interval_n, short_n, long_n, s_m, l_m;
	logic [GAP_W-1:0] since_n;
	logic             pair, match1, match0;

	always_comb begin
		since_n    = (since_q == {GAP_W{1'b1}}) ? since_q : since_q + 1'b1;
		interval_n = (interval_q == 8'hFF) ? interval_q : interval_q + 8'd1;
		low        = sample < cfg.mid_level;
		rise       = (low != level_low_q) && !low;
		is_short   = interval_n >= cfg.short_min && interval_n <= cfg.short_max;
		is_long    = !is_short && interval_n >= cfg.long_min && interval_n <= cfg.long_max;
		pulse      = rise && (is_short || is_long);
		short_n    = (is_short && short_q != 8'hFF) ? short_q + 8'd1 : short_q;
		long_n     = (is_long && long_q != 8'hFF) ? long_q + 8'd1 : long_q;
		pair       = pulse && prev_long_q && is_short;
		// snap counts within one of the nominal pattern
		s_m = short_n;
		if (short_n == 8'd9 || short_n == 8'd11)  s_m = 8'd10;
		if (short_n == 8'd17 || short_n == 8'd19) s_m = 8'd18;
		l_m = long_n;
		if (long_n == 8'd10 || long_n == 8'd12) l_m = 8'd11;
		if (long_n == 8'd5 || long_n == 8'd7)   l_m = 8'd6;
		match1 = s_m == 8'd10 && l_m == 8'd11;
		match0 = s_m == 8'd18 && l_m == 8'd6;
		push   = take && pair && (match1 || match0);
		push_evt.bit_val = match1;
		push_evt.first   = no_bit_yet_q;
		push_evt.gap     = since_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_low_q  <= 1'b1;
			interval_q   <= '0;
			prev_long_q  <= 1'b1;
			short_q      <= '0;
			long_q       <= '0;
			since_q      <= '0;
			no_bit_yet_q <= 1'b1;
		end else if (take) begin
			level_low_q <= low;
			interval_q  <= rise ? 8'd0 : interval_n;
			since_q     <= push ? '0 : since_n;
			if (push) begin
				no_bit_yet_q <= 1'b0;
			end
			if (pulse) begin
				prev_long_q <= is_long;
				// a long-to-short change clears both counts, matched or not
				short_q     <= pair ? 8'd0 : short_n;
				long_q      <= pair ? 8'd0 : long_n;
			end
		end
	end

endmodule

@@ rtl/fskd_queue.sv @@
// Two-entry queue of decoded bits between front and back.
// Depends on fskd_pkg.
module fskd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fskd_pkg::evt_t push_evt,
	input  logic           pop,
	output logic           full,
	output logic           nonempty,
	output fskd_pkg::evt_t head
);
	import fskd_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	evt_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full     = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign nonempty = count_q != '0;
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

endmodule

@@ rtl/fskd_back.sv @@
// Back end: counts gap fillers, then emits fillers and the decoded bit.
// Depends on fskd_pkg; drains fskd_queue.
module fskd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  fskd_pkg::cfg_t cfg,
	input  logic           q_nonempty,
	input  fskd_pkg::evt_t q_head,
	output logic           pop,
	output logic           bit_valid,
	input  logic           bit_ready,
	output logic           bit_value,
	output logic           is_filler,
	output logic           last_of_run,
	output logic           fill_truncated
);
	import fskd_pkg::*;

	bk_state_t         state_q, state_n;
	logic [GAP_W-1:0]  gap_q;
	logic              bit_q;
	logic [FILL_W-1:0] fills_q, sent_q;
	logic              trunc_q;
	logic              ov_q, bv_q, fil_q, last_q, tr_q;

	logic              slot_free, over, more, all_sent, emit_fill, emit_bit;
	logic [31:0]       gap_sub;

	assign slot_free = !ov_q || bit_ready;
	assign over      = 32'(gap_q) > 32'(cfg.gap_limit);
	assign more      = over && fills_q < FILL_W'(FILL_MAX);
	assign all_sent  = sent_q == fills_q;
	assign gap_sub   = (32'(gap_q) > 32'(cfg.bit_period))
	                   ? 32'(gap_q) - 32'(cfg.bit_period) : 32'd0;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			BK_IDLE:  if (q_nonempty) state_n = q_head.first ? BK_EMIT : BK_COUNT;
			BK_COUNT: if (!more) state_n = BK_EMIT;
			BK_EMIT:  if (slot_free && all_sent) state_n = BK_IDLE;
			default:  state_n = BK_IDLE;
		endcase
	end

	always_comb begin
		pop       = state_q == BK_IDLE && q_nonempty;
		emit_fill = state_q == BK_EMIT && slot_free && !all_sent;
		emit_bit  = state_q == BK_EMIT && slot_free && all_sent;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_n;
			if (emit_fill || emit_bit) begin
				ov_q <= 1'b1;
			end else if (bit_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			gap_q   <= q_head.gap;
			bit_q   <= q_head.bit_val;
			fills_q <= '0;
			sent_q  <= '0;
			trunc_q <= 1'b0;
		end else if (state_q == BK_COUNT) begin
			if (more) begin
				fills_q <= fills_q + 1'b1;
				gap_q   <= gap_sub[GAP_W-1:0];
			end else begin
				trunc_q <= over;
			end
		end else if (emit_fill) begin
			sent_q <= sent_q + 1'b1;
		end
		if (emit_fill || emit_bit) begin
			bv_q   <= emit_fill ? 1'b1 : bit_q;
			fil_q  <= emit_fill;
			last_q <= emit_bit;
			tr_q   <= trunc_q;
		end
	end

	assign bit_valid      = ov_q;
	assign bit_value      = bv_q;
	assign is_filler      = fil_q;
	assign last_of_run    = last_q;
	assign fill_truncated = tr_q;

endmodule

@@ rtl/fsk_tape_bit_demodulator_unit.sv @@
// Top level of the FSK tape bit demodulator.
// Depends on fskd_pkg, fskd_regs, fskd_front, fskd_queue and fskd_back.
//
// Usage:
//   Input channel: one 8-bit audio sample per beat (sample_valid/sample_ready).
//   Output channel: one recovered bit per beat (bit_valid/bit_ready) with
//   bit_value, is_filler, last_of_run and fill_truncated.
//   Configuration: APB-style port, registers at byte address 4*index; write
//   only while the block is idle. pready is tied high.
// Timing:
//   The front takes one sample per cycle unless the queue is full; it
//   classifies a rising crossing and matches the pulse counts in that same
//   cycle, and a decoded bit enters a two-entry queue. The back pops it,
//   counts the gap down by bit_period (up to 63 fillers), then emits the
//   fillers and the bit, one beat per cycle unless the receiver stalls; a
//   bit passes the back's idle, count (skipped by the first bit) and emit
//   states, then the output register. sample_ready drops only while the
//   queue is full: bits arriving in a long filler run, or a stalled receiver.
// Reset:
//   arst_n clears most state asynchronously; registers return to defaults.
//   A stalled receiver holds the output register; the back then stops and
//   the queue, then the front, back up behind it.
module fsk_tape_bit_demodulator_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	output logic                        sample_ready,
	input  logic [7:0]                  sample,
	output logic                        bit_valid,
	input  logic                        bit_ready,
	output logic                        bit_value,
	output logic                        is_filler,
	output logic                        last_of_run,
	output logic                        fill_truncated,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fskd_pkg::ADDR_W-1:0] paddr,
	input  logic [fskd_pkg::DATA_W-1:0] pwdata,
	output logic [fskd_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import fskd_pkg::*;

	cfg_t cfg;
	evt_t push_evt, head;
	logic push, pop, full, nonempty, take;

	assign pready       = 1'b1;
	// hold samples off only while a decoded bit might find no room
	assign sample_ready = !full;
	assign take         = sample_valid && sample_ready;

	fskd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	fskd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.take     (take),
		.sample   (sample),
		.push     (push),
		.push_evt (push_evt)
	);

	fskd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_evt (push_evt),
		.pop      (pop),
		.full     (full),
		.nonempty (nonempty),
		.head     (head)
	);

	fskd_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.q_nonempty     (nonempty),
		.q_head         (head),
		.pop            (pop),
		.bit_valid      (bit_valid),
		.bit_ready      (bit_ready),
		.bit_value      (bit_value),
		.is_filler      (is_filler),
		.last_of_run    (last_of_run),
		.fill_truncated (fill_truncated)
	);

endmodule

@@ rtl/fskd_checker.sv @@
// Port-level checks of the demodulator, bound to the top level.
// Depends on fsk_tape_bit_demodulator_unit.
module fskd_checker (
	input logic clk,
	input logic arst_n,
	input logic bit_valid,
	input logic bit_ready,
	input logic bit_value,
	input logic is_filler,
	input logic last_of_run,
	input logic pready
);

	// a stalled beat stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		bit_valid && !bit_ready |=> bit_valid)
		else $error("bit_valid dropped while stalled");

	a_fill_one: assert property (@(posedge clk) disable iff (!arst_n)
		bit_valid && is_filler |-> bit_value)
		else $error("filler bit not 1");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		bit_valid |-> !(is_filler && last_of_run))
		else $error("filler marked as end of run");

	// a taken filler leaves bit_valid high, so no run breaks before its bit
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		bit_valid && bit_ready && is_filler |=> bit_valid)
		else $error("filler run broken before its decoded bit");

	a_pready: assert property (@(posedge clk) pready)
		else $error("pready low");

endmodule

bind fsk_tape_bit_demodulator_unit fskd_checker u_fskd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.bit_valid   (bit_valid),
	.bit_ready   (bit_ready),
	.bit_value   (bit_value),
	.is_filler   (is_filler),
	.last_of_run (last_of_run),
	.pready      (pready)
);

@@ tb/tb_top.sv @@
// Self-checking testbench for fsk_tape_bit_demodulator_unit.
// Feeds synthetic FSK tape audio and compares each recovered bit beat with a
// cycle-free decoder model; depends on fskd_pkg and the RTL under rtl.
`timescale 1ns / 100ps

module tb_top;
	import fskd_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int DRAIN_CYCLES = 140;	// filler count loop plus a full filler run
	localparam int IDLE_PCT     = 32;
	localparam int HOLD_CYCLES  = 600;

	// One recovered bit as seen on the output channel
	typedef struct packed {
		logic bit_value;
		logic is_filler;
		logic last_of_run;
		logic fill_truncated;
	} tape_bit_t;

	logic                clk;
	logic                arst_n       = 1'b0;
	logic                sample_valid = 1'b0;
	logic                sample_ready;
	logic [7:0]          sample       = '0;
	logic                bit_valid;
	logic                bit_ready    = 1'b0;
	logic                bit_value;
	logic                is_filler;
	logic                last_of_run;
	logic                fill_truncated;
	logic                psel         = 1'b0;
	logic                penable      = 1'b0;
	logic                pwrite       = 1'b0;
	logic [ADDR_W-1:0]   paddr        = '0;
	logic [DATA_W-1:0]   pwdata       = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	bit no_idle  = 1'b0;	// both sides run flat out while set
	bit hold_req = 1'b0;	// ask the receiver for one long hold-off

	logic [7:0] corner_samples [10] = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h55,
		8'hAA, 8'h01, 8'hFE, 8'h00, 8'hFF};

	// Tracks the decoder state sample by sample and keeps the recovered bits
	// still owed by the block, oldest first.
	class bit_scoreboard;
		cfg_t             cfg;
		bit               level_low;
		bit [7:0]         interval_cnt;
		bit               prev_long;
		bit [7:0]         short_cnt;
		bit [7:0]         long_cnt;
		bit [GAP_W-1:0]   since_bit;
		bit               no_bit_yet;
		tape_bit_t        owed_bits[$];
		int               errors;

		function new();
			cfg = '{mid_level: 8'd128, short_min: 8'd9, short_max: 8'd16,
				long_min: 8'd17, long_max: 8'd22, gap_limit: 16'd441,
				bit_period: 16'd329};
			level_low    = 1'b1;
			interval_cnt = '0;
			prev_long    = 1'b1;
			short_cnt    = '0;
			long_cnt     = '0;
			since_bit    = '0;
			no_bit_yet   = 1'b1;
			errors       = 0;
		endfunction

		function void owe_bit(bit value, bit filler, bit last, bit trunc);
			tape_bit_t b;
			b.bit_value      = value;
			b.is_filler      = filler;
			b.last_of_run    = last;
			b.fill_truncated = trunc;
			owed_bits.insert(owed_bits.size(), b);
		endfunction

		// Fillers for the gap since the previous bit, then the bit itself
		function void emit_bit(bit value);
			int fills;
			int gap;
			bit trunc;
			fills = 0;
			gap   = since_bit;
			trunc = 1'b0;
			if (!no_bit_yet) begin
				while (gap > cfg.gap_limit && fills < FILL_MAX) begin
					fills++;
					gap = (gap > cfg.bit_period) ? gap - cfg.bit_period : 0;
				end
				trunc = (gap > cfg.gap_limit);
			end
			repeat (fills) owe_bit(1'b1, 1'b1, 1'b0, trunc);
			owe_bit(value, 1'b0, 1'b1, trunc);
			no_bit_yet = 1'b0;
			since_bit  = '0;
		endfunction

		function void take_pulse(bit is_long);
			int s;
			int l;
			if (is_long) begin
				if (long_cnt != 8'hFF) long_cnt++;
			end else begin
				if (short_cnt != 8'hFF) short_cnt++;
			end
			// A long-to-short change closes a cell: match counts with +-1 slack
			if (prev_long && !is_long) begin
				s = short_cnt;
				l = long_cnt;
				if (s == 9 || s == 11) s = 10;
				if (s == 17 || s == 19) s = 18;
				if (l == 10 || l == 12) l = 11;
				if (l == 5 || l == 7) l = 6;
				if (s == 10 && l == 11)
					emit_bit(1'b1);
				else if (s == 18 && l == 6)
					emit_bit(1'b0);
				short_cnt = '0;
				long_cnt  = '0;
			end
			prev_long = is_long;
		endfunction

		function void note_sample(logic [7:0] s);
			bit is_low;
			bit [7:0] w;
			is_low = (s < cfg.mid_level);
			if (since_bit != '1) since_bit++;
			if (interval_cnt != 8'hFF) interval_cnt++;
			if (is_low != level_low) begin
				level_low = is_low;
				if (!is_low) begin
					w = interval_cnt;
					interval_cnt = '0;
					// Short window takes priority where the two overlap
					if (w >= cfg.short_min && w <= cfg.short_max)
						take_pulse(1'b0);
					else if (w >= cfg.long_min && w <= cfg.long_max)
						take_pulse(1'b1);
				end
			end
		endfunction

		function void check_bit(tape_bit_t got);
			tape_bit_t want;
			if (owed_bits.size() == 0) begin
				$error("unexpected bit beat: bit_value %0d is_filler %0d",
					got.bit_value, got.is_filler);
				errors++;
				return;
			end
			want = owed_bits.pop_front();
			if (got.bit_value !== want.bit_value) begin
				$error("bit_value: expected %0d, got %0d", want.bit_value, got.bit_value);
				errors++;
			end
			if (got.is_filler !== want.is_filler) begin
				$error("is_filler: expected %0d, got %0d", want.is_filler, got.is_filler);
				errors++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %0d, got %0d", want.last_of_run,
					got.last_of_run);
				errors++;
			end
			if (got.fill_truncated !== want.fill_truncated) begin
				$error("fill_truncated: expected %0d, got %0d", want.fill_truncated,
					got.fill_truncated);
				errors++;
			end
		endfunction

		function int pending();
			return owed_bits.size();
		endfunction
	endclass

	bit_scoreboard sb;

	fsk_tape_bit_demodulator_unit DUT (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Check every bit beat against the oldest owed bit
	always @(posedge clk) begin
		if (arst_n && bit_valid && bit_ready)
			sb.check_bit('{bit_value, is_filler, last_of_run, fill_truncated});
	end

	// Receiver: random stalls, one long hold-off on request so the block backs up
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				bit_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				bit_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
				bit_ready <= 1'b0;
			end else begin
				bit_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_top: errors");
		$finish;
	end

	function automatic logic [7:0] rand_high();
		return 8'($urandom_range(255, sb.cfg.mid_level));
	endfunction

	function automatic logic [7:0] rand_low();
		if (sb.cfg.mid_level == 0)
			return 8'd0;
		return 8'($urandom_range(sb.cfg.mid_level - 1, 0));
	endfunction

	// Pick a width in a window, at least 2, near its low end; 2 to 12 if empty
	function automatic int pick_width(int lo, int hi);
		int a;
		int b;
		a = (lo < 2) ? 2 : lo;
		b = (hi > a + 20) ? a + 20 : hi;
		if (b < a)
			return $urandom_range(12, 2);
		return $urandom_range(b, a);
	endfunction

	// Offer one sample beat; drop valid only for an idle gap, never between
	// back-to-back beats, and hold the payload until accepted.
	task automatic send_sample(logic [7:0] s);
		if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			sample_valid <= 1'b0;
			do @(posedge clk); while (!no_idle && $urandom_range(99) < IDLE_PCT);
		end
		sample_valid <= 1'b1;
		sample       <= s;
		do @(posedge clk); while (!sample_ready);
		sb.note_sample(s);
	endtask

	// One period: rising edge first, then high, then low up to the next edge
	task automatic send_pulse(int w);
		int h;
		h = $urandom_range(w - 1, 1);
		repeat (h) send_sample(rand_high());
		repeat (w - h) send_sample(rand_low());
	endtask

	// One bit cell: shorts, longs, then the short that closes the cell.
	// Well-formed cells land within the +-1 slack of 10/11 or 18/6.
	task automatic send_cell(bit one, bit well_formed);
		int ns;
		int nl;
		if (well_formed) begin
			ns = (one ? 10 : 18) + $urandom_range(2, 0) - 1;
			nl = (one ? 11 : 6) + $urandom_range(2, 0) - 1;
		end else begin
			ns = $urandom_range(25, 1);
			nl = $urandom_range(25, 0);
		end
		repeat (ns - 1) send_pulse(pick_width(sb.cfg.short_min, sb.cfg.short_max));
		repeat (nl) send_pulse(pick_width(sb.cfg.long_min, sb.cfg.long_max));
		send_pulse(pick_width(sb.cfg.short_min, sb.cfg.short_max));
	endtask

	// Drop valid, let every owed bit come out, then let the back settle
	task automatic wait_idle();
		sample_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// APB write: setup cycle, access cycle, then back to idle
	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(cfg_t c);
		wait_idle();
		write_reg(REG_MID_LEVEL,  DATA_W'(c.mid_level));
		write_reg(REG_SHORT_MIN,  DATA_W'(c.short_min));
		write_reg(REG_SHORT_MAX,  DATA_W'(c.short_max));
		write_reg(REG_LONG_MIN,   DATA_W'(c.long_min));
		write_reg(REG_LONG_MAX,   DATA_W'(c.long_max));
		write_reg(REG_GAP_LIMIT,  DATA_W'(c.gap_limit));
		write_reg(REG_BIT_PERIOD, DATA_W'(c.bit_period));
		sb.cfg = c;
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Corner samples under the reset settings: both rails, both sides of mid
		foreach (corner_samples[i]) send_sample(corner_samples[i]);

		// Fastest tones, zero gap limit and zero period: every bit after the
		// first carries a full, truncated filler run. One low sample first so
		// the edge ahead of the first cell closes an empty cell.
		apply_setting('{8'd128, 8'd2, 8'd2, 8'd3, 8'd3, 16'd0, 16'd0});
		send_sample(rand_low());
		send_cell(1'($urandom_range(1, 0)), 1'b1);

		// Hold the receiver off and keep offering samples flat out: the back
		// sits on a filler run, two more bits fill the queue, the input stalls
		no_idle  = 1'b1;
		hold_req = 1'b1;
		repeat (3) send_cell(1'($urandom_range(1, 0)), 1'b1);
		// the first high sample closes the last cell
		repeat (3) send_sample(rand_high());
		no_idle = 1'b0;

		wait_idle();
		if (sb.errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

@@ fsk_tape_bit_demodulator_unit.f @@
rtl/fskd_pkg.sv
rtl/fskd_regs.sv
rtl/fskd_front.sv
rtl/fskd_queue.sv
rtl/fskd_back.sv
rtl/fsk_tape_bit_demodulator_unit.sv
rtl/fskd_checker.sv
tb/tb_top.sv
